// ===== rtl/core/sa32_pkg.sv =====
`default_nettype none

package sa32_pkg;

    localparam int unsigned POS_W       = 4;
    localparam int unsigned FIELD_BYTES = 4;
    localparam logic [16:0] ADLER_MOD   = 17'd65521;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_req_t;

    typedef struct packed {
        logic [31:0] checksum;
        logic        short_packet;
    } out_req_t;

    typedef struct packed {
        logic    valid;
        in_req_t req;
    } stage_t;

endpackage

`default_nettype wire

// ===== rtl/core/sa32_if.sv =====
`default_nettype none

interface sa32_in_if;
    logic             valid;
    logic             ready;
    sa32_pkg::in_req_t req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

interface sa32_out_if;
    logic              valid;
    logic              ready;
    sa32_pkg::out_req_t req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sctp_adler32_checksum_core.sv =====
// An accepted byte is registered in the input stage and then folded into the sums; for
// a last byte the result is registered in the output register, which drives egress.
// Throughput: one byte per cycle from the sum update loop, while egress is not stalled.
// Reset (rst_n low, asynchronous): sums go to 1 and 0, position to 0, both stages empty.
`default_nettype none

module sctp_adler32_checksum_core #(
    parameter int unsigned HEADER_BYTES = 12
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sa32_in_if.sink   ingress,
    sa32_out_if.source egress
);

    sa32_pkg::stage_t stage;
    logic             take;

    sa32_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .ingress (ingress),
        .take    (take),
        .stage   (stage)
    );

    sa32_accum #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .stage  (stage),
        .take   (take),
        .egress (egress)
    );

endmodule

`default_nettype wire

// ===== rtl/core/sa32_in_stage.sv =====
`default_nettype none

module sa32_in_stage (
    input  wire logic         clk,
    input  wire logic         rst_n,
    sa32_in_if.sink           ingress,
    input  wire logic         take,
    output sa32_pkg::stage_t  stage
);

    logic              valid_reg;
    logic              valid_next;
    sa32_pkg::in_req_t req_reg;
    logic              accept;

    assign ingress.ready = !valid_reg || take;
    assign accept        = ingress.valid && ingress.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= ingress.req;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.req   = req_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sa32_accum.sv =====
`default_nettype none

module sa32_accum #(
    parameter int unsigned HEADER_BYTES = 12
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sa32_pkg::stage_t   stage,
    output logic                    take,
    sa32_out_if.source              egress
);

    localparam logic [sa32_pkg::POS_W-1:0] HDR_POS =
        sa32_pkg::POS_W'(HEADER_BYTES);
    localparam logic [sa32_pkg::POS_W-1:0] FIELD_START =
        sa32_pkg::POS_W'(HEADER_BYTES - sa32_pkg::FIELD_BYTES);

    logic [15:0]                low_reg;
    logic [15:0]                low_next;
    logic [15:0]                high_reg;
    logic [15:0]                high_next;
    logic [sa32_pkg::POS_W-1:0] pos_reg;
    logic [sa32_pkg::POS_W-1:0] pos_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    sa32_pkg::out_req_t         out_req_reg;
    sa32_pkg::out_req_t         out_req_next;

    logic [7:0]                 byte_in;
    logic [16:0]                low_sum;
    logic [15:0]                low_mod;
    logic [16:0]                high_sum;
    logic [15:0]                high_mod;
    logic [sa32_pkg::POS_W-1:0] pos_inc;
    logic                       is_last;

    assign is_last = stage.req.last_byte;
    assign take    = stage.valid && (!is_last || !out_valid_reg || egress.ready);

    always_comb
    begin
        // checksum field inside the common header counts as zero
        byte_in = ((pos_reg < HDR_POS) && (pos_reg >= FIELD_START)) ?
                  8'd0 : stage.req.data_byte;

        low_sum  = {1'b0, low_reg} + {9'd0, byte_in};
        low_mod  = (low_sum >= sa32_pkg::ADLER_MOD) ?
                   16'(low_sum - sa32_pkg::ADLER_MOD) : low_sum[15:0];
        high_sum = {1'b0, high_reg} + {1'b0, low_mod};
        high_mod = (high_sum >= sa32_pkg::ADLER_MOD) ?
                   16'(high_sum - sa32_pkg::ADLER_MOD) : high_sum[15:0];
        pos_inc  = (pos_reg < HDR_POS) ? pos_reg + 1'b1 : pos_reg;

        low_next       = low_reg;
        high_next      = high_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_req_next   = out_req_reg;

        if (out_valid_reg && egress.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (take)
        begin
            if (is_last)
            begin
                low_next       = 16'd1;
                high_next      = 16'd0;
                pos_next       = '0;
                out_valid_next = 1'b1;
                if (pos_inc >= HDR_POS)
                begin
                    out_req_next.checksum     = {high_mod, low_mod};
                    out_req_next.short_packet = 1'b0;
                end
                else
                begin
                    out_req_next.checksum     = 32'd0;
                    out_req_next.short_packet = 1'b1;
                end
            end
            else
            begin
                low_next  = low_mod;
                high_next = high_mod;
                pos_next  = pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= 16'd1;
            high_reg      <= 16'd0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            low_reg       <= low_next;
            high_reg      <= high_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_req_reg <= out_req_next;
    end

    assign egress.valid = out_valid_reg;
    assign egress.req   = out_req_reg;

endmodule

`default_nettype wire
